// ===== hw/rtl/a16as_pkg.sv =====
`default_nettype none

package a16as_pkg;

  // Operation codes carried in the action field.
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_ADC = 3'd1;
  localparam logic [2:0] ACT_SBC = 3'd2;
  localparam logic [2:0] ACT_INC = 3'd3;
  localparam logic [2:0] ACT_DEC = 3'd4;

  // Flag byte bit positions.
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_C  = 0;

  // Flags that ADD leaves as they were.
  localparam logic [7:0] ADD_KEEP_MASK = 8'hC4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] acc_value;
    logic [15:0] operand_value;
    logic [7:0]  flags_in;
  } cmd_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
  } res_t;

  // Adder operands after decode: subtraction is already folded into an
  // inverted operand and an inverted carry.
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        cin;
    logic [2:0]  action;
    logic [7:0]  fin;
  } opnd_t;

  // Sum and context leaving the adder.
  typedef struct packed {
    logic [15:0] sum;
    logic        c16;
    logic        a12;
    logic        b12;
    logic        a15;
    logic        b15;
    logic [2:0]  action;
    logic [7:0]  fin;
  } sum_t;

endpackage

`default_nettype wire

// ===== hw/rtl/a16as_split_add.sv =====
`default_nettype none

module a16as_split_add
  import a16as_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_vld,
  input  wire opnd_t opnd,
  output logic       out_vld,
  output sum_t       sum
);

  // Low byte is added and registered; the high byte finishes from the
  // registered carry in the following stage.
  logic       vld;
  logic [7:0] lo;
  logic       c8;
  logic [7:0] a_hi;
  logic [7:0] b_hi;
  logic [2:0] action;
  logic [7:0] fin;

  logic [8:0] lo_sum;
  logic [8:0] hi_sum;

  assign lo_sum = {1'b0, opnd.a[7:0]} + {1'b0, opnd.b[7:0]} + {8'd0, opnd.cin};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_sum[7:0];
    c8     <= lo_sum[8];
    a_hi   <= opnd.a[15:8];
    b_hi   <= opnd.b[15:8];
    action <= opnd.action;
    fin    <= opnd.fin;
  end

  assign hi_sum = {1'b0, a_hi} + {1'b0, b_hi} + {8'd0, c8};

  always_comb begin
    sum.sum    = {hi_sum[7:0], lo};
    sum.c16    = hi_sum[8];
    sum.a12    = a_hi[4];
    sum.b12    = b_hi[4];
    sum.a15    = a_hi[7];
    sum.b15    = b_hi[7];
    sum.action = action;
    sum.fin    = fin;
  end

  assign out_vld = vld;

endmodule

`default_nettype wire

// ===== hw/rtl/alu16_add_sub_flags.sv =====
`default_nettype none

// 16-bit add/subtract unit with processor flags (S7 Z6 H4 P/V2 N1 C0).
// Each item carries an action (ADD, ADC, SBC, INC, DEC), the accumulator
// pair, the operand pair and the current flag byte; it yields the 16-bit
// result and the new flag byte. An item is taken on any cycle where start
// is high, and busy never rises, so one item per cycle is sustained. The
// result appears with done after operand decode, the low byte of the carry
// chain and the high byte together with the flag logic, each registered
// in turn, the last into the output register. The result is shown for a
// single cycle only; the receiver cannot stall it and must capture it when
// done is high. Unused action codes return the accumulator unchanged with
// the flags passed through.
module alu16_add_sub_flags
  import a16as_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      done,
  output res_t      res
);

  // The pipeline never holds off an item.
  assign busy = 1'b0;

  // Stage 1: decode into adder operands. Subtraction uses the inverted
  // operand with an inverted carry, so one adder serves every action.
  opnd_t opnd_next;
  opnd_t opnd;
  logic  s1_vld;

  always_comb begin
    opnd_next.action = cmd.action;
    opnd_next.fin    = cmd.flags_in;
    case (cmd.action)
      ACT_ADD: begin
        opnd_next.a   = cmd.acc_value;
        opnd_next.b   = cmd.operand_value;
        opnd_next.cin = 1'b0;
      end
      ACT_ADC: begin
        opnd_next.a   = cmd.acc_value;
        opnd_next.b   = cmd.operand_value;
        opnd_next.cin = cmd.flags_in[FLAG_C];
      end
      ACT_SBC: begin
        opnd_next.a   = cmd.acc_value;
        opnd_next.b   = ~cmd.operand_value;
        opnd_next.cin = ~cmd.flags_in[FLAG_C];
      end
      ACT_INC: begin
        opnd_next.a   = cmd.operand_value;
        opnd_next.b   = 16'h0000;
        opnd_next.cin = 1'b1;
      end
      ACT_DEC: begin
        opnd_next.a   = cmd.operand_value;
        opnd_next.b   = 16'hFFFF;
        opnd_next.cin = 1'b0;
      end
      default: begin
        // No operation: the accumulator passes through the adder.
        opnd_next.a   = cmd.acc_value;
        opnd_next.b   = 16'h0000;
        opnd_next.cin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    opnd <= opnd_next;
  end

  // Stage 2 and the adder half of stage 3.
  logic s2_vld;
  sum_t sum;

  a16as_split_add u_add (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s1_vld),
    .opnd    (opnd),
    .out_vld (s2_vld),
    .sum     (sum)
  );

  // Stage 3: flag formation. Because b was inverted for SBC, the xor of
  // bit 12 gives the carry into bit 12 and must be flipped to read as the
  // borrow; the carry out of bit 15 flips the same way. Overflow compares
  // the sign of a against the adder's b input, which covers both cases.
  logic       h_raw;
  logic       ovf;
  logic       szero;
  logic [7:0] flags_next;
  res_t       res_next;

  always_comb begin
    h_raw = sum.a12 ^ sum.b12 ^ sum.sum[12];
    ovf   = (sum.a15 == sum.b15) && (sum.sum[15] != sum.a15);
    szero = (sum.sum == 16'h0000);
    case (sum.action)
      ACT_ADD: begin
        flags_next         = sum.fin & ADD_KEEP_MASK;
        flags_next[FLAG_H] = h_raw;
        flags_next[FLAG_C] = sum.c16;
      end
      ACT_ADC: begin
        flags_next          = 8'h00;
        flags_next[FLAG_S]  = sum.sum[15];
        flags_next[FLAG_Z]  = szero;
        flags_next[FLAG_H]  = h_raw;
        flags_next[FLAG_PV] = ovf;
        flags_next[FLAG_C]  = sum.c16;
      end
      ACT_SBC: begin
        flags_next          = 8'h00;
        flags_next[FLAG_S]  = sum.sum[15];
        flags_next[FLAG_Z]  = szero;
        flags_next[FLAG_H]  = ~h_raw;
        flags_next[FLAG_PV] = ovf;
        flags_next[FLAG_N]  = 1'b1;
        flags_next[FLAG_C]  = ~sum.c16;
      end
      default: begin
        // Increment, decrement and unused codes leave the flags alone.
        flags_next = sum.fin;
      end
    endcase
    res_next.result    = sum.sum;
    res_next.flags_out = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/a16as_checker.sv =====
`default_nettype none

module a16as_checker
  import a16as_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t cmd,
  input wire logic done,
  input wire res_t res
);

  // Every accepted item is later delivered with done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("item not delivered three cycles after start");

  // No result without an accepted item before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching item");

  // Increment wraps and passes the flags through.
  a_inc: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.action, 3) == ACT_INC) |->
      (res.result == $past(cmd.operand_value, 3) + 16'd1) &&
      (res.flags_out == $past(cmd.flags_in, 3)))
    else $error("increment result or flags wrong");

  // ADD clears N and the unused flag bits.
  a_add_n: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.action, 3) == ACT_ADD) |->
      (res.flags_out[FLAG_N] == 1'b0) && (res.flags_out[5] == 1'b0) &&
      (res.flags_out[3] == 1'b0))
    else $error("add left N or an unused flag bit set");

endmodule

bind alu16_add_sub_flags a16as_checker u_a16as_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done),
  .res   (res)
);

`default_nettype wire

// ===== sim/alu16_add_sub_flags_tb.sv =====
`timescale 1ns / 100ps

module alu16_add_sub_flags_tb;
  import a16as_pkg::*;

  // The package names only the five real operations. The three spare codes
  // must behave as a no-op, so they get names here as well.
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  // The block takes one item per cycle. The longest quiet stretch in a correct
  // run is the longest sender gap plus the time the pipeline takes to answer,
  // so this watchdog limit leaves a wide margin.
  localparam int unsigned QUIET_LIMIT    = 400;
  localparam int unsigned DRAIN_LIMIT    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  // No sender gaps are inserted in the final stretch of the random part.
  localparam int unsigned STEADY_TAIL    = 200;

  // Tracks the results that the arithmetic unit still owes. Each accepted
  // command is turned into its expected result and queued. Each strobed
  // result is checked against the oldest queued expectation.
  class alu_result_tracker;
    res_t        pending_results[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Computes the 16-bit result and the new flag byte for one command.
    function res_t compute_alu_result(cmd_t c);
      logic [16:0] wide;
      logic [15:0] a;
      logic [15:0] b;
      logic        carry_in;
      res_t        r;
      a        = c.acc_value;
      b        = c.operand_value;
      carry_in = c.flags_in[FLAG_C];
      r        = '0;
      case (c.action)
        ACT_ADD: begin
          // S, Z and P/V are kept. H and C come from the adder. All other
          // bits are cleared, including N.
          wide = {1'b0, a} + {1'b0, b};
          r.result = wide[15:0];
          r.flags_out = c.flags_in & ADD_KEEP_MASK;
          r.flags_out[FLAG_H] = a[12] ^ b[12] ^ r.result[12];
          r.flags_out[FLAG_C] = wide[16];
        end
        ACT_ADC: begin
          wide = {1'b0, a} + {1'b0, b} + {16'd0, carry_in};
          r.result = wide[15:0];
          r.flags_out[FLAG_S]  = r.result[15];
          r.flags_out[FLAG_Z]  = (r.result == 16'd0);
          r.flags_out[FLAG_H]  = a[12] ^ b[12] ^ r.result[12];
          r.flags_out[FLAG_PV] = ~(a[15] ^ b[15]) & (a[15] ^ r.result[15]);
          r.flags_out[FLAG_C]  = wide[16];
        end
        ACT_SBC: begin
          // In 17 bits, bit 16 of the difference is the borrow out of bit 15.
          wide = {1'b0, a} - {1'b0, b} - {16'd0, carry_in};
          r.result = wide[15:0];
          r.flags_out[FLAG_S]  = r.result[15];
          r.flags_out[FLAG_Z]  = (r.result == 16'd0);
          r.flags_out[FLAG_H]  = a[12] ^ b[12] ^ r.result[12];
          r.flags_out[FLAG_PV] = (a[15] ^ b[15]) & (a[15] ^ r.result[15]);
          r.flags_out[FLAG_N]  = 1'b1;
          r.flags_out[FLAG_C]  = wide[16];
        end
        ACT_INC: begin
          r.result    = b + 16'd1;
          r.flags_out = c.flags_in;
        end
        ACT_DEC: begin
          r.result    = b - 16'd1;
          r.flags_out = c.flags_in;
        end
        default: begin
          r.result    = a;
          r.flags_out = c.flags_in;
        end
      endcase
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_results.push_back(compute_alu_result(c));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result %04h flags %02h arrived with no command outstanding",
               got.result, got.flags_out);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result !== want.result) begin
        $error("result mismatch: expected %04h, got %04h", want.result, got.result);
        mismatch_count++;
      end
      if (got.flags_out !== want.flags_out) begin
        $error("flags_out mismatch: expected %02h, got %02h",
               want.flags_out, got.flags_out);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  res_t res;

  alu_result_tracker tracker;
  int unsigned       quiet_cycles;

  alu16_add_sub_flags dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .res   (res)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The monitor samples at the rising edge. Stimulus only moves at the
  // falling edge, so what is read here is stable. The result check comes
  // before the command is noted; since the pipeline registers the result, a
  // command accepted at this edge can never be the one that is finishing.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        tracker.check_result(res);
      end
      if (start && !busy) begin
        tracker.note_command(cmd);
      end
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("alu16_add_sub_flags_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] act, logic [15:0] a, logic [15:0] b,
                                    logic [7:0] f);
    cmd_t c;
    c.action        = act;
    c.acc_value     = a;
    c.operand_value = b;
    c.flags_in      = f;
    return c;
  endfunction

  // Operand values lean toward the corners where the carry, half-carry and
  // overflow logic is most likely to go wrong. About half of them are fully
  // random.
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    case ($urandom_range(0, 9))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      2:       w = 16'h8000;
      3:       w = 16'h7FFF;
      4:       w = 16'h0FFF ^ 16'($urandom_range(0, 3));
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  function automatic cmd_t random_cmd();
    logic [2:0] act;
    // Spare codes are rare, since they only pass the accumulator through.
    if ($urandom_range(0, 11) == 0) begin
      act = 3'($urandom_range(ACT_SPARE5, ACT_SPARE7));
    end else begin
      act = 3'($urandom_range(ACT_ADD, ACT_DEC));
    end
    return make_cmd(act, pick_word(), pick_word(), 8'($urandom));
  endfunction

  // Presents one item and holds it until the block takes it. start stays
  // high into the next item when no gap follows.
  task automatic send_item(cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Leaves the sender quiet for a few cycles. The command bus carries junk,
  // which must be ignored while start is low.
  task automatic sender_gap(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= random_cmd();
    end
  endtask

  initial begin
    int unsigned waited;
    tracker      = new();
    quiet_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items: every operation at the edges of its range.
    // ADD: the carry out of bit 15, the half carry out of bit 11, and the
    // S, Z and P/V bits kept from the incoming flags.
    send_item(make_cmd(ACT_ADD, 16'hFFFF, 16'h0001, 8'h00));
    send_item(make_cmd(ACT_ADD, 16'h0FFF, 16'h0001, 8'hFF));
    send_item(make_cmd(ACT_ADD, 16'h0000, 16'h0000, 8'hFF));
    send_item(make_cmd(ACT_ADD, 16'hFFFF, 16'hFFFF, 8'h3B));
    // ADC: signed overflow, a zero result with carry, and carry in at both
    // values.
    send_item(make_cmd(ACT_ADC, 16'h7FFF, 16'h0000, 8'h01));
    send_item(make_cmd(ACT_ADC, 16'hFFFF, 16'h0000, 8'h01));
    send_item(make_cmd(ACT_ADC, 16'h8000, 16'h8000, 8'hFE));
    send_item(make_cmd(ACT_ADC, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(make_cmd(ACT_ADC, 16'h0000, 16'h0000, 8'h00));
    // SBC: zero, borrow caused by the carry alone, overflow at the most
    // negative value, a borrow into bit 12, and the full-range corners.
    send_item(make_cmd(ACT_SBC, 16'h0000, 16'h0000, 8'h00));
    send_item(make_cmd(ACT_SBC, 16'h0000, 16'h0000, 8'h01));
    send_item(make_cmd(ACT_SBC, 16'h8000, 16'h0001, 8'h00));
    send_item(make_cmd(ACT_SBC, 16'h1000, 16'h0001, 8'hFE));
    send_item(make_cmd(ACT_SBC, 16'hFFFF, 16'hFFFF, 8'h01));
    send_item(make_cmd(ACT_SBC, 16'h7FFF, 16'hFFFF, 8'hFF));
    // INC and DEC wrap around at both ends, and the flags pass through.
    send_item(make_cmd(ACT_INC, 16'h1234, 16'hFFFF, 8'hFF));
    send_item(make_cmd(ACT_INC, 16'hFFFF, 16'h0000, 8'h00));
    send_item(make_cmd(ACT_DEC, 16'h0000, 16'h0000, 8'hA5));
    send_item(make_cmd(ACT_DEC, 16'hFFFF, 16'hFFFF, 8'h5A));
    // Spare codes return the accumulator and the incoming flags.
    send_item(make_cmd(ACT_SPARE5, 16'hFFFF, 16'h0000, 8'hFF));
    send_item(make_cmd(ACT_SPARE6, 16'h0000, 16'hFFFF, 8'h00));
    send_item(make_cmd(ACT_SPARE7, 16'hA5A5, 16'h5A5A, 8'h81));

    // Random part. Gaps come in bursts. Long runs of back-to-back items in
    // between let the three-stage pipeline fill up. The tail has no gaps at
    // all.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - STEADY_TAIL && (i % 100) < 70 && $urandom_range(0, 4) == 0) begin
        sender_gap($urandom_range(1, 14));
      end
      send_item(random_cmd());
    end

    @(negedge clk);
    start <= 1'b0;

    // Wait for the pipeline to drain. Then allow a few more cycles so that
    // any stray result shows up before the verdict.
    waited = 0;
    while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending_results.size());
      tracker.mismatch_count++;
    end

    if (tracker.mismatch_count == 0) begin
      $display("alu16_add_sub_flags_tb: clean");
    end else begin
      $display("alu16_add_sub_flags_tb: errors");
    end
    $finish;
  end

endmodule
